### rtl/pool2d_pkg.sv
`timescale 1ns / 1ps

package pool2d_pkg;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DATA_W = 16;
    localparam int IDX_W  = 12;

    localparam int PLANE_H    = 1 << ROW_W;
    localparam int PLANE_W    = 1 << COL_W;
    localparam int MAX_KERNEL = 16;

    // Window geometry in signed form: out_row * stride - pad and its bounds.
    localparam int POS_W  = 13;
    // Clipped window area is at most MAX_KERNEL squared.
    localparam int AREA_W = 9;
    // Window sum magnitude reaches MAX_KERNEL^2 * 2^(DATA_W-1).
    localparam int MAG_W  = 24;
    localparam int SUM_W  = MAG_W + 1;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_MAX  = 2'd1;
    localparam logic [1:0] FUNC_AVG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS      = 3'd7;

    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [1:0]               func;
        logic [ROW_W-1:0]         pixel_row;
        logic [COL_W-1:0]         pixel_col;
        logic signed [DATA_W-1:0] pixel_value;
        logic [ROW_W-1:0]         out_row;
        logic [COL_W-1:0]         out_col;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pooled_value;
        logic [IDX_W-1:0]         max_index;
        logic                     window_empty;
    } result_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic bounds;
        logic scan;
        logic div_start;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic div_done;
    } dp_status_t;

endpackage

### rtl/pooling_2d_max_avg_unit.sv
`timescale 1ns / 1ps
// Channel    Signals                        Transfer
// item       start, busy, item              taken when start is high and busy is low
// result     done, result                   shown for one cycle while done is high
// config     cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// A load item leaves busy low. A max query with a nonempty window keeps busy high after
// acceptance through bounds, one read per plane pixel inside the clipped window, drain and
// finish, since the single plane memory port gives one pixel per cycle; done follows in
// the next cycle.
// An average query also passes through the one-bit-per-cycle divider before finish.
// A query whose clipped window is empty skips the scan and the divider: bounds leads to finish.
// Reset idles the controller and restores the register defaults; plane contents are
// undefined until loaded.
// The receiver cannot stall: each result is valid for exactly the cycle done is high.

module pooling_2d_max_avg_unit
    import pool2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  done,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pool2d_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (item.func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    pool2d_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .result    (result),
        .done      (done)
    );

    // Every result closes a query that kept the block busy.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a query in flight");

    // A load or an unused code never makes the block busy and never gives a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !(item.func == FUNC_MAX || item.func == FUNC_AVG))
        |=> (!busy && !done))
        else $error("non-query item started work or gave a result");

    // The done strobe is never high in consecutive cycles.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for more than one cycle");

    // An empty window reports index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.window_empty) |-> (result.max_index == '0))
        else $error("empty window with nonzero index");

endmodule

### rtl/pool2d_div.sv
`timescale 1ns / 1ps

module pool2d_div
    import pool2d_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [AREA_W-1:0]       divisor,
    output logic                    done,
    output logic [DATA_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [AREA_W-1:0] rem_reg;
    logic [AREA_W-1:0] dvs_reg;

    logic [SUM_W-1:0]  mag_full;
    logic [AREA_W:0]   shifted;
    logic [AREA_W+1:0] trial;
    logic              fits;
    logic [MAG_W-1:0]  q_signed;

    assign mag_full = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    assign shifted  = {rem_reg, quo_reg[MAG_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign fits     = !trial[AREA_W+1];

    // Truncation toward zero: divide magnitudes, then restore the sign.
    assign q_signed = neg_reg ? MAG_W'(~quo_reg + 1'b1) : quo_reg;
    assign quotient = q_signed[DATA_W-1:0];
    assign done     = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(MAG_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            quo_reg <= mag_full[MAG_W-1:0];
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? trial[AREA_W-1:0] : shifted[AREA_W-1:0];
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
        end
    end

endmodule

### rtl/pool2d_ctrl.sv
`timescale 1ns / 1ps

module pool2d_ctrl
    import pool2d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] func,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUNDS,
        S_SCAN,
        S_DRAIN,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   avg_reg;
    logic   avg_next;
    logic   is_query;

    assign is_query = (func == FUNC_MAX) || (func == FUNC_AVG);

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && start && (func == FUNC_LOAD);
        cmd.setup     = (state_reg == S_IDLE) && start && is_query;
        cmd.bounds    = (state_reg == S_BOUNDS);
        cmd.scan      = (state_reg == S_SCAN);
        cmd.div_start = (state_reg == S_DIV_GO);
        cmd.finish    = (state_reg == S_FINISH);
        busy          = (state_reg != S_IDLE);
    end

    always_comb
    begin
        state_next = state_reg;
        avg_next   = avg_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && is_query)
                begin
                    state_next = S_BOUNDS;
                    avg_next   = (func == FUNC_AVG);
                end
            end
            S_BOUNDS:
            begin
                state_next = status.empty ? S_FINISH : S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The last read lands in the accumulators at the end of this cycle.
                state_next = avg_reg ? S_DIV_GO : S_FINISH;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            avg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            avg_reg   <= avg_next;
        end
    end

endmodule

### rtl/pool2d_dp.sv
`timescale 1ns / 1ps

module pool2d_dp
    import pool2d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    input  item_t                 item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output dp_status_t            status,
    output result_t               result,
    output logic                  done
);

    // Configuration registers.
    logic [6:0] in_height_reg;
    logic [6:0] in_width_reg;
    logic [4:0] kernel_height_reg;
    logic [4:0] kernel_width_reg;
    logic [4:0] stride_rows_reg;
    logic [4:0] stride_cols_reg;
    logic [3:0] pad_rows_reg;
    logic [3:0] pad_cols_reg;

    // Effective values after clamping.
    logic [6:0] ih;
    logic [6:0] iw;
    logic [4:0] kh;
    logic [4:0] kw;
    logic [4:0] sr;
    logic [4:0] sc;

    logic signed [DATA_W-1:0] plane_mem [PLANE_H*PLANE_W];

    logic                    avg_reg;
    logic signed [POS_W-1:0] hs_reg;
    logic signed [POS_W-1:0] ws_reg;
    logic [10:0]             row_prod;
    logic [10:0]             col_prod;

    logic signed [POS_W-1:0] h_end;
    logic signed [POS_W-1:0] w_end;
    logic signed [POS_W-1:0] h_lim;
    logic signed [POS_W-1:0] w_lim;
    logic signed [POS_W-1:0] ah;
    logic signed [POS_W-1:0] aw;
    logic signed [POS_W-1:0] he;
    logic signed [POS_W-1:0] we;
    logic signed [POS_W-1:0] hl;
    logic signed [POS_W-1:0] wl;
    logic signed [POS_W-1:0] dh;
    logic signed [POS_W-1:0] dw;
    logic signed [POS_W-1:0] ih_s;
    logic signed [POS_W-1:0] iw_s;
    logic                    h_ok;
    logic                    w_ok;

    logic [ROW_W:0]   h_hi_reg;
    logic [COL_W-1:0] w_lo_reg;
    logic [COL_W:0]   w_hi_reg;
    logic [ROW_W-1:0] h_cnt_reg;
    logic [COL_W-1:0] w_cnt_reg;
    logic [4:0]       dh_reg;
    logic [4:0]       dw_reg;
    logic             empty_reg;
    logic             w_wrap;
    logic             h_last;

    logic                     rd_vld_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic [ROW_W-1:0]         rd_h_reg;
    logic [COL_W-1:0]         rd_w_reg;

    logic                     found_reg;
    logic signed [DATA_W-1:0] best_reg;
    logic [ROW_W-1:0]         best_h_reg;
    logic [COL_W-1:0]         best_w_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic [9:0]        area_full;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;
    logic [12:0]       idx_full;

    result_t result_reg;
    logic    done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg     <= 7'd64;
            in_width_reg      <= 7'd64;
            kernel_height_reg <= 5'd2;
            kernel_width_reg  <= 5'd2;
            stride_rows_reg   <= 5'd2;
            stride_cols_reg   <= 5'd2;
            pad_rows_reg      <= 4'd0;
            pad_cols_reg      <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_HEIGHT:     in_height_reg     <= cfg_data;
                REG_IN_WIDTH:      in_width_reg      <= cfg_data;
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[4:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[4:0];
                REG_STRIDE_ROWS:   stride_rows_reg   <= cfg_data[4:0];
                REG_STRIDE_COLS:   stride_cols_reg   <= cfg_data[4:0];
                REG_PAD_ROWS:      pad_rows_reg      <= cfg_data[3:0];
                REG_PAD_COLS:      pad_cols_reg      <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        ih = (in_height_reg == '0) ? 7'd1 :
             (in_height_reg > 7'(PLANE_H)) ? 7'(PLANE_H) : in_height_reg;
        iw = (in_width_reg == '0) ? 7'd1 :
             (in_width_reg > 7'(PLANE_W)) ? 7'(PLANE_W) : in_width_reg;
        kh = (kernel_height_reg == '0) ? 5'd1 :
             (kernel_height_reg > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : kernel_height_reg;
        kw = (kernel_width_reg == '0) ? 5'd1 :
             (kernel_width_reg > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : kernel_width_reg;
        sr = (stride_rows_reg == '0) ? 5'd1 : stride_rows_reg;
        sc = (stride_cols_reg == '0) ? 5'd1 : stride_cols_reg;
    end

    // Pixel loads go straight into the plane; reads happen only while scanning.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            plane_mem[{item.pixel_row, item.pixel_col}] <= item.pixel_value;
        end
        if (cmd.scan)
        begin
            rd_data_reg <= plane_mem[{h_cnt_reg, w_cnt_reg}];
        end
    end

    assign row_prod = 11'(item.out_row * sr);
    assign col_prod = 11'(item.out_col * sc);

    always_comb
    begin
        ih_s  = $signed({6'd0, ih});
        iw_s  = $signed({6'd0, iw});
        h_end = hs_reg + $signed({8'd0, kh});
        w_end = ws_reg + $signed({8'd0, kw});
        h_lim = $signed({6'd0, ih} + {9'd0, pad_rows_reg});
        w_lim = $signed({6'd0, iw} + {9'd0, pad_cols_reg});
        ah    = (h_end < h_lim) ? h_end : h_lim;
        aw    = (w_end < w_lim) ? w_end : w_lim;
        he    = (ah < ih_s) ? ah : ih_s;
        we    = (aw < iw_s) ? aw : iw_s;
        hl    = (hs_reg < 0) ? '0 : hs_reg;
        wl    = (ws_reg < 0) ? '0 : ws_reg;
        h_ok  = hl < he;
        w_ok  = wl < we;
        dh    = ah - hs_reg;
        dw    = aw - ws_reg;
    end

    assign w_wrap = (({1'b0, w_cnt_reg} + 1'b1) == w_hi_reg);
    assign h_last = (({1'b0, h_cnt_reg} + 1'b1) == h_hi_reg);

    assign status.empty     = !(h_ok && w_ok);
    assign status.scan_last = w_wrap && h_last;
    assign status.div_done  = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            avg_reg <= (item.func == FUNC_AVG);
            hs_reg  <= $signed({2'b00, row_prod} - {9'd0, pad_rows_reg});
            ws_reg  <= $signed({2'b00, col_prod} - {9'd0, pad_cols_reg});
        end
        if (cmd.bounds)
        begin
            h_hi_reg  <= he[ROW_W:0];
            w_lo_reg  <= wl[COL_W-1:0];
            w_hi_reg  <= we[COL_W:0];
            h_cnt_reg <= hl[ROW_W-1:0];
            w_cnt_reg <= wl[COL_W-1:0];
            dh_reg    <= dh[4:0];
            dw_reg    <= dw[4:0];
            empty_reg <= !(h_ok && w_ok);
        end
        else if (cmd.scan)
        begin
            if (w_wrap)
            begin
                w_cnt_reg <= w_lo_reg;
                h_cnt_reg <= h_cnt_reg + 1'b1;
            end
            else
            begin
                w_cnt_reg <= w_cnt_reg + 1'b1;
            end
        end
        rd_h_reg <= h_cnt_reg;
        rd_w_reg <= w_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan;
            done_reg   <= cmd.finish;
        end
    end

    // Accumulators see one pixel per cycle, in the cycle after its read address.
    always_ff @(posedge clk)
    begin
        if (cmd.bounds)
        begin
            found_reg <= 1'b0;
            sum_reg   <= '0;
        end
        else if (rd_vld_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
            if (!found_reg || (rd_data_reg > best_reg))
            begin
                found_reg  <= 1'b1;
                best_reg   <= rd_data_reg;
                best_h_reg <= rd_h_reg;
                best_w_reg <= rd_w_reg;
            end
        end
    end

    assign area_full = dh_reg * dw_reg;

    pool2d_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (area_full[AREA_W-1:0]),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign idx_full = 13'(best_h_reg * iw) + {7'd0, best_w_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (empty_reg)
            begin
                result_reg.pooled_value <= avg_reg ? '0 : MOST_NEGATIVE;
                result_reg.max_index    <= '0;
                result_reg.window_empty <= 1'b1;
            end
            else if (avg_reg)
            begin
                result_reg.pooled_value <= $signed(div_quot);
                result_reg.max_index    <= '0;
                result_reg.window_empty <= 1'b0;
            end
            else
            begin
                result_reg.pooled_value <= best_reg;
                result_reg.max_index    <= idx_full[IDX_W-1:0];
                result_reg.window_empty <= 1'b0;
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
